/* hw/rtl/rth_pkg.sv */
// rth_pkg: shared types and constants for the rgb to hsv converter
// used by rth_front, rth_div_cell, rth_out and the top level
// no dependencies
`default_nettype none

package rth_pkg;

  // channel and result widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned HueW   = 15;
  localparam int unsigned DataInW  = 24;
  localparam int unsigned DataOutW = 32;

  // quotient bits per division, one per cell in the chain
  localparam int unsigned QuotW    = 12;
  localparam int unsigned NumCells = QuotW;

  // remainder and shifted divisor width (255 * 3840 < 2**20)
  localparam int unsigned RemW = 20;

  // hue scale: 60 degrees is 3840, a full turn is 23040
  localparam int unsigned HueSixth = 3840;
  localparam int unsigned HueTurn  = 23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rth_sector_e;

  // work carried from cell to cell
  typedef struct packed {
    logic [RemW-1:0]  rem_s;   // saturation remainder
    logic [RemW-1:0]  div_s;   // saturation divisor, shifted
    logic [RemW-1:0]  rem_h;   // hue remainder
    logic [RemW-1:0]  div_h;   // hue divisor, shifted
    logic [QuotW-1:0] q_s;     // saturation quotient so far
    logic [QuotW-1:0] q_h;     // hue quotient so far
    logic [ChanW-1:0] hi;      // largest channel
    logic             zero_d;  // max equals min
    rth_sector_e      sector;  // channel that holds the max
    logic             neg;     // hue offset is subtracted
  } rth_work_t;

endpackage

`default_nettype wire

/* hw/rtl/rth_front.sv */
// rth_front: first stage, finds max and min, sector and both dividends
// depends on rth_pkg
`default_nettype none

module rth_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rth_pkg::rth_work_t out_work_o
);
  import rth_pkg::*;

  logic [ChanW-1:0] hi, lo, delta, mag;
  logic             neg;
  rth_sector_e      sector;
  logic [15:0]      num_s;
  logic [RemW-1:0]  num_h;
  rth_work_t        work_d, work_q;
  logic             valid_q;

  // max, min and the channel difference of the chosen sector
  always_comb begin
    hi = (red_i > green_i) ? red_i : green_i;
    lo = (red_i > green_i) ? green_i : red_i;
    if (blue_i > hi) begin
      hi = blue_i;
    end
    if (blue_i < lo) begin
      lo = blue_i;
    end
    delta = hi - lo;
    if (red_i == hi) begin
      sector = SEC_RED;
      neg    = green_i < blue_i;
      mag    = neg ? (blue_i - green_i) : (green_i - blue_i);
    end else if (green_i == hi) begin
      sector = SEC_GREEN;
      neg    = blue_i < red_i;
      mag    = neg ? (red_i - blue_i) : (blue_i - red_i);
    end else begin
      sector = SEC_BLUE;
      neg    = red_i < green_i;
      mag    = neg ? (green_i - red_i) : (red_i - green_i);
    end
    num_s = {delta, 8'd0} - {8'd0, delta};
    num_h = RemW'(mag) * RemW'(HueSixth);
  end

  // dividends and divisors aligned to the top quotient bit
  always_comb begin
    work_d.rem_s  = RemW'(num_s);
    work_d.div_s  = RemW'({hi, (QuotW - 1)'(0)});
    work_d.rem_h  = num_h;
    work_d.div_h  = RemW'({delta, (QuotW - 1)'(0)});
    work_d.q_s    = '0;
    work_d.q_h    = '0;
    work_d.hi     = hi;
    work_d.zero_d = (delta == '0);
    work_d.sector = sector;
    work_d.neg    = neg;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;

endmodule

`default_nettype wire

/* hw/rtl/rth_div_cell.sv */
// rth_div_cell: one restoring division step for saturation and hue each
// depends on rth_pkg
`default_nettype none

module rth_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rth_pkg::rth_work_t in_work_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rth_pkg::rth_work_t out_work_o
);
  import rth_pkg::*;

  logic      ge_s, ge_h;
  rth_work_t work_d, work_q;
  logic      valid_q;

  // compare, subtract and shift the divisor down one place
  always_comb begin
    work_d       = in_work_i;
    ge_s         = in_work_i.rem_s >= in_work_i.div_s;
    ge_h         = in_work_i.rem_h >= in_work_i.div_h;
    work_d.rem_s = ge_s ? (in_work_i.rem_s - in_work_i.div_s) : in_work_i.rem_s;
    work_d.rem_h = ge_h ? (in_work_i.rem_h - in_work_i.div_h) : in_work_i.rem_h;
    work_d.div_s = in_work_i.div_s >> 1;
    work_d.div_h = in_work_i.div_h >> 1;
    work_d.q_s   = {in_work_i.q_s[QuotW-2:0], ge_s};
    work_d.q_h   = {in_work_i.q_h[QuotW-2:0], ge_h};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // cell valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // cell payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;

endmodule

`default_nettype wire

/* hw/rtl/rth_out.sv */
// rth_out: last stage, adds the sector base to the hue and holds the result
// depends on rth_pkg
`default_nettype none

module rth_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rth_pkg::rth_work_t in_work_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        hue_o,
  output logic [7:0]         saturation_o,
  output logic [7:0]         brightness_o
);
  import rth_pkg::*;

  logic signed [HueW+1:0] base, hue_raw, hue_wrap;
  logic [HueW-1:0]        hue_d, hue_q;
  logic [ChanW-1:0]       sat_d, sat_q, bright_q;
  logic                   valid_q;

  // sector base plus or minus the quotient, wrapped into one turn
  always_comb begin
    case (in_work_i.sector)
      SEC_RED:   base = '0;
      SEC_GREEN: base = (HueW+2)'(2 * HueSixth);
      SEC_BLUE:  base = (HueW+2)'(4 * HueSixth);
      default:   base = '0;
    endcase
    if (in_work_i.neg) begin
      hue_raw = base - $signed((HueW+2)'(in_work_i.q_h));
    end else begin
      hue_raw = base + $signed((HueW+2)'(in_work_i.q_h));
    end
    hue_wrap = (hue_raw < 0) ? (hue_raw + (HueW+2)'(HueTurn)) : hue_raw;
    hue_d    = in_work_i.zero_d ? '0 : hue_wrap[HueW-1:0];
    sat_d    = (in_work_i.hi == '0) ? '0 : in_work_i.q_s[ChanW-1:0];
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= in_work_i.hi;
    end
  end

  assign out_valid_o  = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_hsv_converter.sv */
// rgb_to_hsv_converter: top level, front stage, chain of division cells, output stage
// depends on rth_pkg, rth_front, rth_div_cell, rth_out
`default_nettype none

// Converts one 8-bit RGB pixel to HSV per clock unless the output stalls.
// Brightness is the largest channel, saturation is floor((max-min)*255/max)
// and hue is in 1/64 degree (0..23039, 0 for grey and black). A pixel
// passes through one front stage, a row of 12 division cells that each settle
// one quotient bit of both divisions, and one output register. Every stage
// has its own handshake, so a new pixel is taken every cycle unless the output
// stalls, and a stalled output only holds back the stages that are full.
module rgb_to_hsv_converter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rth_pkg::DataInW-1:0]  s_axis_tdata_i,  // red [7:0], green [15:8],
                                                         // blue [23:16]
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [rth_pkg::DataOutW-1:0] m_axis_tdata_o   // hue [14:0], saturation [22:15],
                                                         // brightness [30:23], zero [31]
);
  import rth_pkg::*;

  logic      valid   [NumCells+1];
  logic      ready   [NumCells+1];
  rth_work_t work    [NumCells+1];
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] sat, bright;

  // front stage
  rth_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .red_i       (s_axis_tdata_i[7:0]),
    .green_i     (s_axis_tdata_i[15:8]),
    .blue_i      (s_axis_tdata_i[23:16]),
    .out_valid_o (valid[0]),
    .out_ready_i (ready[0]),
    .out_work_o  (work[0])
  );

  // chain of division cells, most significant quotient bit first
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[i]),
      .in_ready_o  (ready[i]),
      .in_work_i   (work[i]),
      .out_valid_o (valid[i+1]),
      .out_ready_i (ready[i+1]),
      .out_work_o  (work[i+1])
    );
  end

  // output stage
  rth_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid[NumCells]),
    .in_ready_o   (ready[NumCells]),
    .in_work_i    (work[NumCells]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .hue_o        (hue),
    .saturation_o (sat),
    .brightness_o (bright)
  );

  assign m_axis_tdata_o = {1'b0, bright, sat, hue};

endmodule

`default_nettype wire

/* hw/rtl/rth_checker.sv */
// rth_checker: port-level checks on the converter output, bound to the top level
// depends on rgb_to_hsv_converter
`default_nettype none

module rth_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [31:0] m_tdata_i
);

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result dropped while stalled");

  // hue stays within one turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[14:0] < 15'd23040))
    else $error("hue out of range");

  // no saturation means no hue
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tdata_i[22:15] == 8'd0) |-> (m_tdata_i[14:0] == 15'd0))
    else $error("hue set on grey pixel");

  // black pixel has no saturation
  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tdata_i[30:23] == 8'd0) |-> (m_tdata_i[22:15] == 8'd0))
    else $error("saturation set on black pixel");

endmodule

bind rgb_to_hsv_converter rth_checker u_rth_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire
